FILE: rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// Touch contact slot tracker package
// Shared constants, register indexes and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcst_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SlotOutW  = 3;
  localparam int unsigned CountOutW = 3;

  localparam logic [7:0] REPORT_ID_TOUCH = 8'h04;
  localparam logic [3:0] NIBBLE_MASK     = 4'hF;
  localparam logic [7:0] TIP_MASK        = 8'h01;

  localparam logic [CfgIdxW-1:0] CFG_MAX_X = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_Y = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // a report is taken this cycle
    logic emit;    // send one result this cycle
  } tcst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;   // the report on the inputs is a touch report
    logic last;    // the result sent this cycle is the final one
  } tcst_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tcst_ctrl.sv
// ----------------------------------------------------------------------------
// Touch contact slot tracker controller
// Sequences the slot update cycle and the result emission cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module tcst_ctrl
  import tcst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire tcst_stat_t stat_i,
  output tcst_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    busy_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = start_i;
        // Reports with another identifier are dropped without any result.
        if (start_i && stat_i.id_ok) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        busy_o     = 1'b1;
        cmd_o.emit = 1'b1;
        if (stat_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcst_dp.sv
// ----------------------------------------------------------------------------
// Touch contact slot tracker datapath
// Holds the configured limits, the slot table and the result registers,
// and walks the active slots one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcst_dp
  import tcst_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 5
)(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tcst_cmd_t             cmd_i,
  output tcst_stat_t                 stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CoordW-1:0]     cfg_data_i,
  input  wire logic [7:0]            report_id_i,
  input  wire logic [7:0]            status_byte_i,
  input  wire logic [CoordW-1:0]     pos_x_i,
  input  wire logic [CoordW-1:0]     pos_y_i,
  output logic                       result_valid_o,
  output logic [SlotOutW-1:0]        contact_slot_o,
  output logic [CoordW-1:0]          contact_x_o,
  output logic [CoordW-1:0]          contact_y_o,
  output logic [CountOutW-1:0]       active_count_o,
  output logic                       contact_valid_o,
  output logic                       last_of_run_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);

  logic [CoordW-1:0] max_x_q, max_y_q;
  logic [CoordW-1:0] slot_x_q [NUM_SLOTS];
  logic [CoordW-1:0] slot_y_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  logic [CntW-1:0] count_q, count_d;

  logic [CoordW-1:0] clamp_x, clamp_y;
  logic [3:0]        cid;
  logic              tip;
  logic              cid_ok;
  logic              upd;
  logic [SlotW-1:0]  sel;
  logic [NUM_SLOTS-1:0] pend_rest;
  logic [4:0]        sel_wide;
  logic [4:0]        count_wide;

  assign clamp_x = (pos_x_i > max_x_q) ? max_x_q : pos_x_i;
  assign clamp_y = (pos_y_i > max_y_q) ? max_y_q : pos_y_i;
  assign cid     = status_byte_i[7:4] & NIBBLE_MASK;
  assign tip     = (status_byte_i & TIP_MASK) != 8'h00;
  assign cid_ok  = {1'b0, cid} < 5'(NUM_SLOTS);

  assign stat_o.id_ok = (report_id_i == REPORT_ID_TOUCH);
  assign upd          = cmd_i.accept && stat_o.id_ok && cid_ok;

  // Slot activity after this report, and its population count.
  always_comb begin
    active_d = active_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (upd && (cid == 4'(i))) begin
        active_d[i] = tip;
      end
    end
    count_d = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      count_d = count_d + CntW'(active_d[i]);
    end
  end

  // Lowest pending slot is the next one to send.
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = SlotW'(i);
      end
    end
  end

  assign pend_rest   = pend_q & (pend_q - NUM_SLOTS'(1));
  assign stat_o.last = (pend_rest == '0);

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.accept) begin
      pend_d = active_d;
    end else if (cmd_i.emit) begin
      pend_d = pend_rest;
    end
  end

  assign sel_wide   = 5'(sel);
  assign count_wide = 5'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q        <= '1;
      max_y_q        <= '1;
      active_q       <= '0;
      pend_q         <= '0;
      count_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAX_X: max_x_q <= cfg_data_i;
          CFG_MAX_Y: max_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      active_q       <= active_d;
      pend_q         <= pend_d;
      if (cmd_i.accept) begin
        count_q <= count_d;
      end
      result_valid_o <= cmd_i.emit;
    end
  end

  // Positions are only read once their slot has been written.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (upd && (cid == 4'(i))) begin
        slot_x_q[i] <= clamp_x;
        slot_y_q[i] <= clamp_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      last_of_run_o <= stat_o.last;
      if (pend_q == '0) begin
        // No active contact: a single empty result.
        contact_valid_o <= 1'b0;
        contact_slot_o  <= '0;
        contact_x_o     <= '0;
        contact_y_o     <= '0;
        active_count_o  <= '0;
      end else begin
        contact_valid_o <= 1'b1;
        contact_slot_o  <= sel_wide[SlotOutW-1:0];
        contact_x_o     <= slot_x_q[sel];
        contact_y_o     <= slot_y_q[sel];
        active_count_o  <= count_wide[CountOutW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/touch_contact_slot_tracker_top.sv
// ----------------------------------------------------------------------------
// Touch contact slot tracker
// Keeps per-slot contact positions from touchpad reports and lists the
// active contacts after each report.
// ----------------------------------------------------------------------------
// A report is taken when start_i is high and busy_o is low. A report whose
// identifier is not 4 is dropped in that cycle and gives no result. Any other
// report updates the slot its contact id names (if below NUM_SLOTS) in the
// accept cycle, then the block sends one result per active slot, in slot
// order, one per cycle, and stays busy while it does so (when none is active
// it sends a single empty result). Each result appears on the result ports
// in the cycle after it is picked, for exactly one cycle, marked by
// result_valid_o; it must be taken then. Results are read from the slot
// table one slot at a time.
// The configuration channel is always ready and must only be written while
// no report is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_contact_slot_tracker_top
  import tcst_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 5
)(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [7:0]            report_id_i,
  input  wire logic [7:0]            status_byte_i,
  input  wire logic [CoordW-1:0]     pos_x_i,
  input  wire logic [CoordW-1:0]     pos_y_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CoordW-1:0]     cfg_data_i,
  output logic                       result_valid_o,
  output logic [SlotOutW-1:0]        contact_slot_o,
  output logic [CoordW-1:0]          contact_x_o,
  output logic [CoordW-1:0]          contact_y_o,
  output logic [CountOutW-1:0]       active_count_o,
  output logic                       contact_valid_o,
  output logic                       last_of_run_o
);

  tcst_cmd_t  cmd;
  tcst_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tcst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  tcst_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .report_id_i     (report_id_i),
    .status_byte_i   (status_byte_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .result_valid_o  (result_valid_o),
    .contact_slot_o  (contact_slot_o),
    .contact_x_o     (contact_x_o),
    .contact_y_o     (contact_y_o),
    .active_count_o  (active_count_o),
    .contact_valid_o (contact_valid_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
